### hdl/tvt_pkg.sv
`default_nettype none

package tvt_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 256;

  typedef struct packed {
    logic        mode;
    logic [31:0] bid_order;
    logic [31:0] ask_order;
    logic [23:0] trade_price;
    logic [23:0] trade_quantity;
    logic [47:0] trade_time;
    logic [7:0]  history_slot;
  } tvt_in_t;

  typedef struct packed {
    logic [31:0] record_id;
    logic [31:0] record_bid;
    logic [31:0] record_ask;
    logic [23:0] record_price;
    logic [23:0] record_quantity;
    logic [47:0] record_time;
    logic        record_valid;
    logic [39:0] volume_total;
    logic [39:0] count_total;
    logic [31:0] vwap;
  } tvt_out_t;

  typedef struct packed {
    logic [31:0] trade_id;
    logic [31:0] bid;
    logic [31:0] ask;
    logic [23:0] price;
    logic [23:0] quantity;
    logic [47:0] stamp;
  } tvt_rec_t;

  localparam logic MODE_TRADE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

endpackage

`default_nettype wire

### hdl/trade_vwap_tracker_core.sv
// Trade: product, accumulate, range check, then a 32-step restoring divide at one quotient
//   bit per cycle; the result is registered in S_FIN, which waits while the output stalls.
// History read: registered ring read, then out in S_FIN; in_ready is high only in S_IDLE.
// Zero volume or quotient overflow skips the divide.
// Reset (rst_n low, synchronous) empties the ring, zeroes the totals and sets the next id to 1;
//   ring contents are not cleared.
`default_nettype none

module trade_vwap_tracker_core
  import tvt_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tvt_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tvt_out_t      out_data
);

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CW = (FW > 8) ? FW : 8;
  localparam int unsigned SW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [AW-1:0] HEAD_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(HISTORY_DEPTH);
  localparam logic [39:0]   DEPTH_40  = 40'(HISTORY_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_ACC, S_CHK, S_DIV, S_FIN} state_t;

  state_t        state_r;
  logic [AW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [31:0]   next_id_r;
  logic [39:0]   vol_r;
  logic [63:0]   pv_r;
  logic [39:0]   cnt_acc_r;
  logic [31:0]   vwap_r;
  logic [47:0]   pq_r;
  logic [39:0]   rem_r;
  logic [31:0]   num_r;
  logic [4:0]    step_r;
  logic          is_read_r;
  logic          rd_hit_r;
  tvt_rec_t      rec_r;
  tvt_rec_t      rd_data_r;
  logic          out_valid_r;
  tvt_out_t      out_r;

  tvt_rec_t      ring_r [HISTORY_DEPTH];

  logic          in_xfer;
  logic          wr_en;
  logic          rd_en;
  logic          full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] rd_wrap;
  logic          slot_hit;
  tvt_rec_t      new_rec;
  tvt_rec_t      fin_rec;
  logic [40:0]   vol_sum;
  logic [39:0]   vol_nxt;
  logic [40:0]   cnt_sum;
  logic [39:0]   cnt_nxt;
  logic [64:0]   pv_sum;
  logic [63:0]   pv_nxt;
  logic [40:0]   div_t;
  logic [40:0]   div_diff;
  logic          div_ge;
  logic [39:0]   rem_nxt;
  logic          out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign wr_en    = in_xfer && (in_data.mode == MODE_TRADE);
  assign rd_en    = in_xfer && (in_data.mode == MODE_READ);
  assign full     = (fill_r == FILL_FULL);
  // head only moves once the ring is full, so below that fill is the free slot
  assign wr_addr  = full ? head_r : fill_r[AW-1:0];

  assign slot_hit = CW'(in_data.history_slot) < CW'(fill_r);
  assign rd_sum   = SW'(head_r) + SW'(in_data.history_slot);
  assign rd_wrap  = (rd_sum >= DEPTH_S) ? (rd_sum - DEPTH_S) : rd_sum;
  assign rd_addr  = rd_wrap[AW-1:0];

  assign new_rec = '{
    trade_id: next_id_r,
    bid:      in_data.bid_order,
    ask:      in_data.ask_order,
    price:    in_data.trade_price,
    quantity: in_data.trade_quantity,
    stamp:    in_data.trade_time
  };

  assign vol_sum = {1'b0, vol_r} + 41'(in_data.trade_quantity);
  assign vol_nxt = vol_sum[40] ? '1 : vol_sum[39:0];
  assign cnt_sum = {1'b0, cnt_acc_r} + 41'd1;
  assign cnt_nxt = cnt_sum[40] ? '1 : cnt_sum[39:0];
  assign pv_sum  = {1'b0, pv_r} + 65'(pq_r);
  assign pv_nxt  = pv_sum[64] ? '1 : pv_sum[63:0];

  // restoring divide of {pv, 8'h00} by volume, one quotient bit per cycle
  assign div_t    = {rem_r, num_r[31]};
  assign div_ge   = (div_t >= {1'b0, vol_r});
  assign div_diff = div_t - {1'b0, vol_r};
  assign rem_nxt  = div_ge ? div_diff[39:0] : div_t[39:0];

  assign out_free = !out_valid_r || out_ready;
  assign fin_rec  = is_read_r ? (rd_hit_r ? rd_data_r : tvt_rec_t'('0)) : rec_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_r[wr_addr] <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      next_id_r   <= 32'd1;
      vol_r       <= '0;
      pv_r        <= '0;
      cnt_acc_r   <= '0;
      vwap_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (wr_en) begin
            rec_r     <= new_rec;
            is_read_r <= 1'b0;
            next_id_r <= next_id_r + 32'd1;
            vol_r     <= vol_nxt;
            cnt_acc_r <= cnt_nxt;
            pq_r      <= 48'(in_data.trade_price) * 48'(in_data.trade_quantity);
            if (full) begin
              head_r <= (head_r == HEAD_LAST) ? '0 : head_r + AW'(1);
            end else begin
              fill_r <= fill_r + FW'(1);
            end
            state_r <= S_ACC;
          end else if (rd_en) begin
            is_read_r <= 1'b1;
            rd_hit_r  <= slot_hit;
            state_r   <= S_FIN;
          end
        end
        S_ACC: begin
          pv_r    <= pv_nxt;
          state_r <= S_CHK;
        end
        S_CHK: begin
          priority if (vol_r == '0) begin
            vwap_r  <= '0;
            state_r <= S_FIN;
          end else if (pv_r[63:24] >= vol_r) begin
            vwap_r  <= '1;
            state_r <= S_FIN;
          end else begin
            rem_r   <= pv_r[63:24];
            num_r   <= {pv_r[23:0], 8'h00};
            step_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          num_r  <= {num_r[30:0], div_ge};
          step_r <= step_r + 5'd1;
          if (step_r == 5'd31) begin
            vwap_r  <= {num_r[30:0], div_ge};
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_r.record_id       <= fin_rec.trade_id;
            out_r.record_bid      <= fin_rec.bid;
            out_r.record_ask      <= fin_rec.ask;
            out_r.record_price    <= fin_rec.price;
            out_r.record_quantity <= fin_rec.quantity;
            out_r.record_time     <= fin_rec.stamp;
            out_r.record_valid    <= is_read_r ? rd_hit_r : 1'b1;
            out_r.volume_total    <= vol_r;
            out_r.count_total     <= cnt_acc_r;
            out_r.vwap            <= vwap_r;
            out_valid_r           <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("ring fill beyond depth");

  a_head_full: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != '0) |-> full)
    else $error("ring head moved before ring full");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_acc_r < DEPTH_40) |-> (40'(fill_r) == cnt_acc_r))
    else $error("ring fill disagrees with trade count");

  a_vwap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (vol_r == '0)) |-> (vwap_r == '0))
    else $error("vwap nonzero with zero volume");

  a_div_trade: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> ((state_r == S_DIV) || (state_r == S_FIN)) && !is_read_r)
    else $error("divide left on a read transfer");

endmodule

`default_nettype wire
